FILE: rtl/core/pic_pkg.sv
`default_nettype none

package pic_pkg;

    // Fixed field widths of the bus access and the result
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 6;
    localparam int SRC_LINES_W = 40;

    // Slot entry: valid bit over a source id
    localparam int ID_W     = 6;
    localparam int ID_SPACE = 1 << ID_W;
    localparam int SLOT_W   = ID_W + 1;

    // Parameter defaults
    localparam int NUM_SOURCES_DEF    = 40;
    localparam int PRIORITY_SLOTS_DEF = 40;

    // Access kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Register map
    localparam logic [IDX_W-1:0] REG_MASK_LO   = 6'd0;
    localparam logic [IDX_W-1:0] REG_MASK_HI   = 6'd1;
    localparam logic [IDX_W-1:0] REG_LEVEL_LO  = 6'd2;
    localparam logic [IDX_W-1:0] REG_LEVEL_HI  = 6'd3;
    localparam logic [IDX_W-1:0] REG_PENDING   = 6'd4;
    localparam logic [IDX_W-1:0] REG_SLOT_BASE = 6'd8;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_SLOT,
        ST_FIN
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;   // latch the accepted beat
        logic exec;      // apply a write, clear the search
        logic scan;      // read the slot under the scan counter, advance
        logic slot_rd;   // read the slot named by the request
        logic finish;    // load the result register
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_last; // scan counter sits on the last slot
        logic out_free;  // result register can take a beat
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: rtl/core/pic_ctrl.sv
`default_nettype none

module pic_ctrl
    import pic_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through apply, scan, slot read and finish
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_last) n_state = ST_SLOT;
            end
            ST_SLOT: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Drive commands for the current state
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_SLOT: begin
                o_cmd.slot_rd = 1'b1;
            end
            ST_FIN: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/pic_dp.sv
`default_nettype none

module pic_dp
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES    = NUM_SOURCES_DEF,
    parameter int PRIORITY_SLOTS = PRIORITY_SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_sts                     o_sts,
    input  wire logic                   i_req_type,
    input  wire logic [IDX_W-1:0]       i_reg_index,
    input  wire logic [DATA_W-1:0]      i_write_data,
    input  wire logic [SRC_LINES_W-1:0] i_source_lines,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [DATA_W-1:0]           o_read_data,
    output logic                        o_irq_line,
    output logic                        o_fiq_line
);

    localparam int SLOT_AW = (PRIORITY_SLOTS > 1) ? $clog2(PRIORITY_SLOTS) : 1;
    localparam int IDXE_W  = IDX_W + 1;
    localparam int HALF_W  = ID_SPACE / 2;

    // Latched request
    logic                   r_req_type;
    logic [IDX_W-1:0]       r_idx;
    logic [DATA_W-1:0]      r_wdata;
    logic [NUM_SOURCES-1:0] r_lines;

    // Programmed state
    logic [NUM_SOURCES-1:0] r_enable;
    logic [NUM_SOURCES-1:0] r_fiq_sel;
    logic [NUM_SOURCES-1:0] n_enable;
    logic [NUM_SOURCES-1:0] n_fiq_sel;

    // Slot memory with written bits
    logic [SLOT_W-1:0]         mem_slot [PRIORITY_SLOTS];
    logic [PRIORITY_SLOTS-1:0] r_slot_wr;
    logic [SLOT_W-1:0]         r_mem_q;
    logic                      r_mem_qw;
    logic                      r_eval;

    // Scan and search
    logic [SLOT_AW-1:0] r_cnt;
    logic               r_irq_hit;
    logic [ID_W-1:0]    r_irq_id;
    logic               r_fiq_hit;
    logic [ID_W-1:0]    r_fiq_id;

    // Result register
    logic              r_out_vld;
    logic [DATA_W-1:0] r_rdata;
    logic              r_irq;
    logic              r_fiq;
    logic [DATA_W-1:0] n_rdata;

    logic [ID_SPACE-1:0] lines_ext;
    logic [ID_SPACE-1:0] en_ext;
    logic [ID_SPACE-1:0] sel_ext;
    logic [ID_SPACE-1:0] pend_ext;
    logic [ID_SPACE-1:0] irq_cand;
    logic [ID_SPACE-1:0] fiq_cand;
    logic [IDX_W-1:0]    slot_off;
    logic                slot_hit;
    logic [SLOT_AW-1:0]  slot_addr;
    logic [SLOT_AW-1:0]  rd_addr;
    logic                is_write;
    logic                slot_ok;
    logic [ID_W-1:0]     q_id;
    logic                irq_m;
    logic                fiq_m;

    // Merge one 32-bit half into a source vector
    function automatic logic [NUM_SOURCES-1:0] f_merge(
        input logic [NUM_SOURCES-1:0] old_v,
        input logic [DATA_W-1:0]      d,
        input logic                   hi
    );
        logic [NUM_SOURCES-1:0] v;
        v = old_v;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if ((i >= HALF_W) == hi) v[i] = d[i % DATA_W];
        end
        return v;
    endfunction

    assign lines_ext = ID_SPACE'(i_source_lines);
    assign en_ext    = ID_SPACE'(r_enable);
    assign sel_ext   = ID_SPACE'(r_fiq_sel);
    assign pend_ext  = ID_SPACE'(r_lines) & en_ext;
    assign irq_cand  = pend_ext & ~sel_ext;
    assign fiq_cand  = pend_ext & sel_ext;

    // Decode the slot address of the request
    assign slot_off  = r_idx - REG_SLOT_BASE;
    assign slot_hit  = (r_idx >= REG_SLOT_BASE) &&
                       ({1'b0, slot_off} < IDXE_W'(PRIORITY_SLOTS));
    assign slot_addr = slot_off[SLOT_AW-1:0];
    assign rd_addr   = i_cmd.scan ? r_cnt : slot_addr;
    assign is_write  = (r_req_type == REQ_WRITE);

    // Latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_idx      <= i_reg_index;
            r_wdata    <= i_write_data;
            r_lines    <= lines_ext[NUM_SOURCES-1:0];
        end
    end

    // Compute mask and level updates
    always_comb begin
        n_enable  = r_enable;
        n_fiq_sel = r_fiq_sel;
        if (i_cmd.exec && is_write) begin
            unique case (r_idx)
                REG_MASK_LO:  n_enable  = f_merge(r_enable, r_wdata, 1'b0);
                REG_MASK_HI:  n_enable  = f_merge(r_enable, r_wdata, 1'b1);
                REG_LEVEL_LO: n_fiq_sel = f_merge(r_fiq_sel, r_wdata, 1'b0);
                REG_LEVEL_HI: n_fiq_sel = f_merge(r_fiq_sel, r_wdata, 1'b1);
                default: begin
                    n_enable  = r_enable;
                    n_fiq_sel = r_fiq_sel;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= '0;
            r_fiq_sel <= '0;
        end else begin
            r_enable  <= n_enable;
            r_fiq_sel <= n_fiq_sel;
        end
    end

    // Write a slot, keeping only valid and id
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && is_write && slot_hit) begin
            mem_slot[slot_addr] <= {r_wdata[DATA_W-1], r_wdata[ID_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_wr <= '0;
        end else if (i_cmd.exec && is_write && slot_hit) begin
            r_slot_wr[slot_addr] <= 1'b1;
        end
    end

    // Read one slot a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan || i_cmd.slot_rd) begin
            r_mem_q  <= mem_slot[rd_addr];
            r_mem_qw <= r_slot_wr[rd_addr];
        end
    end

    // Advance the scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_eval <= 1'b0;
        end else begin
            r_eval <= i_cmd.scan;
            if (i_cmd.exec) begin
                r_cnt <= '0;
            end else if (i_cmd.scan) begin
                r_cnt <= r_cnt + SLOT_AW'(1);
            end
        end
    end

    assign o_sts.scan_last = (r_cnt == SLOT_AW'(PRIORITY_SLOTS - 1));

    // Match the slot read last cycle against both routes
    assign slot_ok = r_mem_qw && r_mem_q[SLOT_W-1];
    assign q_id    = r_mem_q[ID_W-1:0];
    assign irq_m   = r_eval && slot_ok && irq_cand[q_id];
    assign fiq_m   = r_eval && slot_ok && fiq_cand[q_id];

    // Keep the first match of each route
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_hit <= 1'b0;
            r_irq_id  <= '0;
            r_fiq_hit <= 1'b0;
            r_fiq_id  <= '0;
        end else if (i_cmd.exec) begin
            r_irq_hit <= 1'b0;
            r_irq_id  <= '0;
            r_fiq_hit <= 1'b0;
            r_fiq_id  <= '0;
        end else begin
            if (irq_m && !r_irq_hit) begin
                r_irq_hit <= 1'b1;
                r_irq_id  <= q_id;
            end
            if (fiq_m && !r_fiq_hit) begin
                r_fiq_hit <= 1'b1;
                r_fiq_id  <= q_id;
            end
        end
    end

    // Compose read data
    always_comb begin
        n_rdata = '0;
        if (!is_write) begin
            unique case (r_idx)
                REG_MASK_LO:  n_rdata = en_ext[DATA_W-1:0];
                REG_MASK_HI:  n_rdata = en_ext[ID_SPACE-1:HALF_W];
                REG_LEVEL_LO: n_rdata = sel_ext[DATA_W-1:0];
                REG_LEVEL_HI: n_rdata = sel_ext[ID_SPACE-1:HALF_W];
                REG_PENDING: begin
                    n_rdata = {r_irq_hit, 9'd0, r_irq_id, r_fiq_hit, 9'd0, r_fiq_id};
                end
                default: begin
                    if (slot_hit && r_mem_qw) begin
                        n_rdata = {r_mem_q[SLOT_W-1], {(DATA_W-SLOT_W){1'b0}},
                                   r_mem_q[ID_W-1:0]};
                    end
                end
            endcase
        end
    end

    // Hold the result beat until taken
    assign o_sts.out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_rdata <= n_rdata;
            r_irq   <= r_irq_hit;
            r_fiq   <= r_fiq_hit;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_read_data = r_rdata;
    assign o_irq_line  = r_irq;
    assign o_fiq_line  = r_fiq;

endmodule

`default_nettype wire

FILE: rtl/core/priority_interrupt_controller.sv
`default_nettype none

// Programmable priority interrupt controller. Each input beat is one register
// access (read or write) that also samples the source request lines; each
// access returns one result beat with the read data (zero for a write) and
// the IRQ and FIQ line levels computed after the write. Registers: 0/1 enable
// mask low/high, 2/3 FIQ routing low/high, 4 read-only highest-pending word
// (IRQ valid bit 31, IRQ id 21:16, FIQ valid bit 15, FIQ id 5:0), 8 and up the
// priority slots (valid bit 31, source id 5:0), slot 0 highest. From its
// acceptance until its result is loaded, an access applies a write, searches
// the priority slots one at a time because the slot memory has a single read
// port, reads the addressed slot and loads the result. The next beat is
// accepted in the cycle after the result is loaded; a result that is still
// stalled at the output holds the next access in its final state until it
// can be loaded.
// The input accepts a new beat while the previous result still waits.
module priority_interrupt_controller
    import pic_pkg::*;
#(
    parameter int NUM_SOURCES    = NUM_SOURCES_DEF,
    parameter int PRIORITY_SLOTS = PRIORITY_SLOTS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic                   i_req_type,
    input  wire logic [IDX_W-1:0]       i_reg_index,
    input  wire logic [DATA_W-1:0]      i_write_data,
    input  wire logic [SRC_LINES_W-1:0] i_source_lines,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [DATA_W-1:0]           o_read_data,
    output logic                        o_irq_line,
    output logic                        o_fiq_line
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequence each access
    pic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Registers, slot memory and search
    pic_dp #(
        .NUM_SOURCES    (NUM_SOURCES),
        .PRIORITY_SLOTS (PRIORITY_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_type     (i_req_type),
        .i_reg_index    (i_reg_index),
        .i_write_data   (i_write_data),
        .i_source_lines (i_source_lines),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_irq_line     (o_irq_line),
        .o_fiq_line     (o_fiq_line)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import pic_pkg::*;

    localparam int N_SRC     = NUM_SOURCES_DEF;
    localparam int N_SLOT    = PRIORITY_SLOTS_DEF;
    localparam int N_RANDOM  = 1350;
    localparam int PHASE_LEN = 450;
    localparam int DRAIN_CYC = 2 * N_SLOT + 16;
    localparam logic [SRC_LINES_W-1:0] ALL_LINES = '1;

    // One result beat: read data plus both interrupt lines
    typedef struct {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic              fiq;
    } t_bus_reply;

    // Directed row; the reply fields count only where has_reply is set
    typedef struct {
        logic                   rq;
        logic [IDX_W-1:0]       ix;
        logic [DATA_W-1:0]      wd;
        logic [SRC_LINES_W-1:0] sl;
        bit                     has_reply;
        logic [DATA_W-1:0]      rd;
        logic                   irq;
        logic                   fiq;
    } t_access_row;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic                   i_req_type     = REQ_READ;
    logic [IDX_W-1:0]       i_reg_index    = '0;
    logic [DATA_W-1:0]      i_write_data   = '0;
    logic [SRC_LINES_W-1:0] i_source_lines = '0;
    logic                   i_out_stall    = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [DATA_W-1:0]      o_read_data;
    logic                   o_irq_line;
    logic                   o_fiq_line;

    // Shadow copy of the controller registers
    logic [N_SRC-1:0] en_mask;
    logic [N_SRC-1:0] fiq_sel;
    logic [ID_W:0]    slot_tbl [N_SLOT];

    t_bus_reply  reply_q [$];
    t_access_row dir_rows [$];
    int          n_errors     = 0;
    int          in_idle_pct  = 9;
    int          out_stall_pct = 51;

    priority_interrupt_controller u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_reg_index    (i_reg_index),
        .i_write_data   (i_write_data),
        .i_source_lines (i_source_lines),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_irq_line     (o_irq_line),
        .o_fiq_line     (o_fiq_line)
    );

    always #1 i_clk = ~i_clk;

    // Return {found, id} of the first valid slot naming a candidate source
    function automatic logic [ID_W:0] winning_slot(input logic [N_SRC-1:0] cand);
        logic [ID_W:0] hit;
        hit = '0;
        for (int k = N_SLOT - 1; k >= 0; k--) begin
            if (slot_tbl[k][ID_W] && int'(slot_tbl[k][ID_W-1:0]) < N_SRC
                    && cand[slot_tbl[k][ID_W-1:0]])
                hit = {1'b1, slot_tbl[k][ID_W-1:0]};
        end
        return hit;
    endfunction

    // Apply one access to the shadow registers and return its reply
    function automatic t_bus_reply resolve_access(input logic rq, input logic [IDX_W-1:0] ix,
                                                  input logic [DATA_W-1:0] wd,
                                                  input logic [SRC_LINES_W-1:0] sl);
        t_bus_reply    reply;
        logic [N_SRC-1:0] pend;
        logic [ID_W:0] irq_hit;
        logic [ID_W:0] fiq_hit;
        bit            is_slot;
        int            slot_k;
        is_slot = int'(ix) >= int'(REG_SLOT_BASE) && int'(ix) < int'(REG_SLOT_BASE) + N_SLOT;
        slot_k  = int'(ix) - int'(REG_SLOT_BASE);
        reply.read_data = '0;
        // Writes land first; the pending word is read-only
        if (rq == REQ_WRITE) begin
            case (ix)
                REG_MASK_LO:  en_mask[31:0]       = wd;
                REG_MASK_HI:  en_mask[N_SRC-1:32] = wd[N_SRC-33:0];
                REG_LEVEL_LO: fiq_sel[31:0]       = wd;
                REG_LEVEL_HI: fiq_sel[N_SRC-1:32] = wd[N_SRC-33:0];
                default: if (is_slot) slot_tbl[slot_k] = {wd[31], wd[ID_W-1:0]};
            endcase
        end
        pend    = sl[N_SRC-1:0] & en_mask;
        irq_hit = winning_slot(pend & ~fiq_sel);
        fiq_hit = winning_slot(pend & fiq_sel);
        if (rq == REQ_READ) begin
            case (ix)
                REG_MASK_LO:  reply.read_data = en_mask[31:0];
                REG_MASK_HI:  reply.read_data = 32'(en_mask[N_SRC-1:32]);
                REG_LEVEL_LO: reply.read_data = fiq_sel[31:0];
                REG_LEVEL_HI: reply.read_data = 32'(fiq_sel[N_SRC-1:32]);
                REG_PENDING:  reply.read_data = {irq_hit[ID_W], 9'b0, irq_hit[ID_W-1:0],
                                                 fiq_hit[ID_W], 9'b0, fiq_hit[ID_W-1:0]};
                default: if (is_slot)
                    reply.read_data = {slot_tbl[slot_k][ID_W], 25'b0,
                                       slot_tbl[slot_k][ID_W-1:0]};
            endcase
        end
        reply.irq = irq_hit[ID_W];
        reply.fiq = fiq_hit[ID_W];
        return reply;
    endfunction

    // Queue the expected reply, then present the beat until it is taken
    task automatic issue_access(input logic rq, input logic [IDX_W-1:0] ix,
                                input logic [DATA_W-1:0] wd, input logic [SRC_LINES_W-1:0] sl,
                                input bit has_reply, input t_bus_reply typed_reply);
        t_bus_reply predicted;
        predicted = resolve_access(rq, ix, wd, sl);
        reply_q.push_back(has_reply ? typed_reply : predicted);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= rq;
        i_reg_index    <= ix;
        i_write_data   <= wd;
        i_source_lines <= sl;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Check each result beat against the oldest expectation; drive a random stall
    always @(posedge i_clk) begin
        t_bus_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reply_q.size() == 0) begin
                $error("result beat with no access outstanding");
                n_errors++;
            end else begin
                want = reply_q.pop_front();
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %08h, got %08h", want.read_data, o_read_data);
                    n_errors++;
                end
                if (o_irq_line !== want.irq) begin
                    $error("irq_line: expected %0b, got %0b", want.irq, o_irq_line);
                    n_errors++;
                end
                if (o_fiq_line !== want.fiq) begin
                    $error("fiq_line: expected %0b, got %0b", want.fiq, o_fiq_line);
                    n_errors++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    initial begin
        logic                   rq;
        logic [IDX_W-1:0]       ix;
        logic [DATA_W-1:0]      wd;
        logic [SRC_LINES_W-1:0] sl;
        int                     pick;
        t_bus_reply             no_reply;

        no_reply = '{'0, 1'b0, 1'b0};
        en_mask  = '0;
        fiq_sel  = '0;
        foreach (slot_tbl[k]) slot_tbl[k] = '0;

        // Reset values, range limits, special indexes
        dir_rows.push_back('{REQ_READ,  REG_MASK_LO,  32'hFFFF_FFFF, ALL_LINES, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_READ,  REG_PENDING,  32'h0, ALL_LINES, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_READ,  REG_SLOT_BASE, 32'h0, ALL_LINES, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_READ,  6'd47,        32'h0, ALL_LINES, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, REG_MASK_LO,  32'hFFFF_FFFF, ALL_LINES, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, REG_MASK_HI,  32'hFFFF_FFFF, '0, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_READ,  REG_MASK_HI,  32'h0, '0, 1, 32'h0000_00FF, 0, 0});
        dir_rows.push_back('{REQ_WRITE, REG_LEVEL_HI, 32'hFFFF_FFFF, '0, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_READ,  REG_LEVEL_HI, 32'h0, '0, 1, 32'h0000_00FF, 0, 0});
        dir_rows.push_back('{REQ_WRITE, REG_LEVEL_LO, 32'h0000_0001, '0, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, REG_SLOT_BASE, 32'hFFFF_FFC5, '0, 1, 32'h0, 0, 0});
        dir_rows.push_back('{REQ_READ,  REG_SLOT_BASE, 32'h0, '0, 1, 32'h8000_0005, 0, 0});
        // Out-of-range id, FIQ source, duplicate id, cleared valid bit
        dir_rows.push_back('{REQ_WRITE, 6'd9,  32'h8000_003F, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, 6'd10, 32'h8000_0027, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, 6'd11, 32'h8000_0005, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, 6'd12, 32'h7FFF_FFC0, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_READ,  REG_PENDING, 32'h0, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_READ,  REG_PENDING, 32'h0, 40'h80_0000_0001, 0, '0, 0, 0});
        // Read-only and unmapped indexes, then the last slot and the low mask
        dir_rows.push_back('{REQ_WRITE, REG_PENDING, 32'hFFFF_FFFF, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_READ,  6'd5,  32'hFFFF_FFFF, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, 6'd7,  32'hFFFF_FFFF, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, 6'd63, 32'hFFFF_FFFF, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_READ,  6'd63, 32'h0, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, 6'd47, 32'h8000_0000, ALL_LINES, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_READ,  6'd47, 32'h0, 40'h00_0000_0001, 0, '0, 0, 0});
        dir_rows.push_back('{REQ_WRITE, REG_MASK_LO, 32'h0, ALL_LINES, 0, '0, 0, 0});

        // Hold reset, then release it
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            issue_access(dir_rows[r].rq, dir_rows[r].ix, dir_rows[r].wd, dir_rows[r].sl,
                         dir_rows[r].has_reply,
                         '{dir_rows[r].rd, dir_rows[r].irq, dir_rows[r].fiq});
        end

        // Random accesses, weighted toward slot setup and pending-word reads
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == PHASE_LEN) begin
                in_idle_pct   = 51;
                out_stall_pct = 9;
            end else if (n == 2 * PHASE_LEN) begin
                in_idle_pct   = 0;
                out_stall_pct = 0;
            end
            rq   = ($urandom_range(99) < 45) ? REQ_WRITE : REQ_READ;
            pick = $urandom_range(99);
            if (pick < 30)
                ix = REG_PENDING;
            else if (pick < 45)
                ix = IDX_W'($urandom_range(int'(REG_LEVEL_HI)));
            else if (pick < 90)
                ix = REG_SLOT_BASE + IDX_W'($urandom_range(N_SLOT - 1));
            else
                ix = IDX_W'($urandom_range(63));
            wd = $urandom;
            if (int'(ix) >= int'(REG_SLOT_BASE)) begin
                if ($urandom_range(3) != 0) wd[ID_W-1:0] = ID_W'($urandom_range(N_SRC - 1));
                if ($urandom_range(3) != 0) wd[31] = 1'b1;
            end else if ($urandom_range(3) == 0) begin
                wd = '1;
            end
            pick = $urandom_range(99);
            sl   = SRC_LINES_W'({$urandom, $urandom});
            if (pick < 30)
                sl = sl & SRC_LINES_W'({$urandom, $urandom} & {$urandom, $urandom});
            else if (pick < 40)
                sl = SRC_LINES_W'(1) << $urandom_range(N_SRC - 1);
            else if (pick < 45)
                sl = ALL_LINES;
            else if (pick < 50)
                sl = '0;
            issue_access(rq, ix, wd, sl, 0, no_reply);
        end
        i_in_valid <= 1'b0;

        // Drain outstanding replies, then watch for stray beats
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Bound the run
    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
